// ----- hdl/rsx_pkg.sv -----
// shared types and codes for the risc16 subset execute unit
`default_nettype none
package rsx_pkg;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_READ  = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_SQ_HALT = 2'd2;
    localparam logic [1:0] ST_SEQ_ERR = 2'd3;

    localparam logic [31:0] SQ_AREA = 32'hF000_0000;
    localparam logic [15:0] OP_NOP  = 16'h0009;

    typedef enum logic [1:0] {
        DP_NONE  = 2'd0,
        DP_ENTER = 2'd1,
        DP_SLOT  = 2'd2
    } dphase_t;

    typedef struct packed {
        logic        action;
        logic [15:0] opcode;
        logic [31:0] load_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  mem_op;
        logic [1:0]  mem_size;
        logic [31:0] mem_addr;
        logic [31:0] write_data;
        logic [31:0] next_pc;
        logic        t_bit;
        logic [1:0]  status;
    } out_item_t;

    typedef struct packed {
        logic [31:0] pc;
        logic        t;
        logic [31:0] macl;
        dphase_t     dphase;
        logic [31:0] jtarget;
        logic        ld_pend;
        logic [3:0]  ld_dest;
        logic        ld_half;
        logic        halted;
    } arch_t;

    typedef struct packed {
        logic        en_a;
        logic [3:0]  addr_a;
        logic [31:0] data_a;
        logic        en_b;
        logic [3:0]  addr_b;
        logic [31:0] data_b;
    } rf_wr_t;

    function automatic logic [31:0] sx8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage
`default_nettype wire

// ----- hdl/rsx_exec.sv -----
// combinational decode and execute of one beat
`default_nettype none
module rsx_exec
    import rsx_pkg::*;
(
    input  in_item_t    item,
    input  logic [31:0] rn,
    input  logic [31:0] rm,
    input  logic [31:0] r0,
    input  arch_t       cur,
    output arch_t       nxt,
    output rf_wr_t      wr,
    output out_item_t   res
);

    always_comb
    begin
        logic [15:0] op;
        logic [3:0]  n;
        logic [3:0]  m;
        logic        known;
        logic        sq;
        logic        jumped;
        logic        bf_taken;
        logic [1:0]  mop;
        logic [1:0]  msz;
        logic [31:0] maddr;
        logic [31:0] wdata;
        logic [31:0] tmp;
        logic [31:0] boff;
        arch_t       s;
        rf_wr_t      w;

        op       = item.opcode;
        n        = op[11:8];
        m        = op[7:4];
        known    = 1'b1;
        sq       = 1'b0;
        jumped   = 1'b0;
        bf_taken = 1'b0;
        mop      = MEM_NONE;
        msz      = SZ_BYTE;
        maddr    = '0;
        wdata    = '0;
        tmp      = '0;
        boff     = sx8(op[7:0]);
        s        = cur;
        w        = '0;
        nxt      = cur;
        wr       = '0;
        res      = '0;

        if (cur.halted || (item.action && !cur.ld_pend) || (!item.action && cur.ld_pend))
        begin
            res.next_pc = cur.pc;
            res.t_bit   = cur.t;
            res.status  = ST_SEQ_ERR;
        end
        else if (item.action)
        begin
            wr.en_a     = 1'b1;
            wr.addr_a   = cur.ld_dest;
            wr.data_a   = cur.ld_half ? sx16(item.load_data[15:0]) : item.load_data;
            nxt.ld_pend = 1'b0;
            res.next_pc = cur.pc;
            res.t_bit   = cur.t;
            res.status  = ST_OK;
        end
        else
        begin
            case (op[15:12])
                4'h0:
                begin
                    if (op[7:0] == 8'h83)
                        sq = (rn >= SQ_AREA);
                    else if (op == OP_NOP)
                        known = 1'b1;
                    else if (op[7:0] == 8'h1A)
                    begin
                        w.en_a = 1'b1; w.addr_a = n; w.data_a = cur.macl;
                    end
                    else
                        known = 1'b0;
                end
                4'h1:
                begin
                    mop = MEM_WRITE; msz = SZ_WORD;
                    maddr = rn + {26'd0, op[3:0], 2'b00}; wdata = rm;
                end
                4'h2:
                begin
                    case (op[3:0])
                        4'h0: begin mop = MEM_WRITE; msz = SZ_BYTE; maddr = rn;
                                    wdata = {24'd0, rm[7:0]}; end
                        4'h1: begin mop = MEM_WRITE; msz = SZ_HALF; maddr = rn;
                                    wdata = {16'd0, rm[15:0]}; end
                        4'h8: s.t = ((rm & rn) == 32'd0);
                        4'hA: begin w.en_a = 1'b1; w.addr_a = n; w.data_a = rn ^ rm; end
                        4'hE: s.macl = {16'd0, rn[15:0]} * {16'd0, rm[15:0]};
                        default: known = 1'b0;
                    endcase
                end
                4'h3:
                begin
                    case (op[3:0])
                        4'h0: s.t = (rn == rm);
                        4'h6: s.t = (rn > rm);
                        default: known = 1'b0;
                    endcase
                end
                4'h4:
                begin
                    w.addr_a = n;
                    case (op[7:0])
                        8'h10: begin tmp = rn - 32'd1; s.t = (tmp == 32'd0);
                                     w.en_a = 1'b1; w.data_a = tmp; end
                        8'h01: begin s.t = rn[0]; w.en_a = 1'b1;
                                     w.data_a = {1'b0, rn[31:1]}; end
                        8'h21: begin s.t = rn[0]; w.en_a = 1'b1;
                                     w.data_a = {rn[31], rn[31:1]}; end
                        8'h05: begin s.t = rn[0]; w.en_a = 1'b1;
                                     w.data_a = {rn[0], rn[31:1]}; end
                        8'h08: begin w.en_a = 1'b1; w.data_a = {rn[29:0], 2'b00}; end
                        8'h18: begin w.en_a = 1'b1; w.data_a = {rn[23:0], 8'd0}; end
                        8'h28: begin w.en_a = 1'b1; w.data_a = {rn[15:0], 16'd0}; end
                        8'h09: begin w.en_a = 1'b1; w.data_a = {2'b00, rn[31:2]}; end
                        8'h2B: begin s.jtarget = rn; jumped = 1'b1; end
                        default: known = 1'b0;
                    endcase
                end
                4'h5:
                begin
                    mop = MEM_READ; msz = SZ_WORD;
                    maddr = rm + {26'd0, op[3:0], 2'b00};
                    s.ld_dest = n; s.ld_half = 1'b0;
                end
                4'h6:
                begin
                    w.addr_a = n;
                    case (op[3:0])
                        4'h3: begin w.en_a = 1'b1; w.data_a = rm; end
                        4'h5:
                        begin
                            mop = MEM_READ; msz = SZ_HALF; maddr = rm;
                            s.ld_dest = n; s.ld_half = 1'b1;
                            w.en_b = (m != n); w.addr_b = m; w.data_b = rm + 32'd2;
                        end
                        4'h8: begin w.en_a = 1'b1;
                                    w.data_a = {rm[31:16], rm[7:0], rm[15:8]}; end
                        4'h9: begin w.en_a = 1'b1; w.data_a = {rm[15:0], rm[31:16]}; end
                        default: known = 1'b0;
                    endcase
                end
                4'h7:
                begin
                    w.en_a = 1'b1; w.addr_a = n; w.data_a = rn + sx8(op[7:0]);
                end
                4'h8:
                begin
                    case (n)
                        4'h1: begin mop = MEM_WRITE; msz = SZ_HALF;
                                    maddr = rm + {27'd0, op[3:0], 1'b0};
                                    wdata = {16'd0, r0[15:0]}; end
                        4'h5: begin mop = MEM_READ; msz = SZ_HALF;
                                    maddr = rm + {27'd0, op[3:0], 1'b0};
                                    s.ld_dest = 4'd0; s.ld_half = 1'b1; end
                        4'hB: bf_taken = !cur.t;
                        default: known = 1'b0;
                    endcase
                end
                4'h9:
                begin
                    mop = MEM_READ; msz = SZ_HALF;
                    maddr = cur.pc + 32'd4 + {23'd0, op[7:0], 1'b0};
                    s.ld_dest = n; s.ld_half = 1'b1;
                end
                4'hC:
                begin
                    w.addr_a = 4'd0;
                    case (n)
                        4'h7: begin w.en_a = 1'b1;
                                    w.data_a = {cur.pc[31:2], 2'b00} + 32'd4
                                             + {22'd0, op[7:0], 2'b00}; end
                        4'h8: s.t = ((r0[7:0] & op[7:0]) == 8'd0);
                        4'hB: begin w.en_a = 1'b1; w.data_a = r0 | {24'd0, op[7:0]}; end
                        default: known = 1'b0;
                    endcase
                end
                4'hE:
                begin
                    w.en_a = 1'b1; w.addr_a = n; w.data_a = sx8(op[7:0]);
                end
                default: known = 1'b0;
            endcase

            if (!known || sq)
            begin
                nxt.halted  = 1'b1;
                res.next_pc = cur.pc;
                res.t_bit   = cur.t;
                res.status  = known ? ST_SQ_HALT : ST_UNKNOWN;
            end
            else
            begin
                if (mop == MEM_READ)
                    s.ld_pend = 1'b1;
                if (cur.dphase == DP_SLOT && !jumped)
                begin
                    s.pc     = cur.jtarget;
                    s.dphase = DP_NONE;
                end
                else
                begin
                    s.pc = bf_taken ? (cur.pc + 32'd4 + {boff[30:0], 1'b0})
                                    : (cur.pc + 32'd2);
                    s.dphase = (jumped || cur.dphase == DP_ENTER) ? DP_SLOT : DP_NONE;
                end
                if (jumped)
                    s.dphase = DP_SLOT;
                nxt            = s;
                wr             = w;
                res.mem_op     = mop;
                res.mem_size   = msz;
                res.mem_addr   = maddr;
                res.write_data = wdata;
                res.next_pc    = s.pc;
                res.t_bit      = s.t;
                res.status     = ST_OK;
            end
        end
    end

endmodule
`default_nettype wire

// ----- hdl/risc16_subset_execute_unit_core.sv -----
// top level of the risc16 subset execute unit: operand stage, state and result register
`default_nettype none
// Executes one 16-bit opcode, or one load return, per beat and gives exactly one
// result beat for each. An accepted beat waits in the operand register,
// where Rn, Rm and R0 are already read (with bypass of the write made in that same
// cycle), then passes through the execute logic into the result register. A new
// beat can be taken every cycle while the result register is free or being drained;
// the operand register lets one more beat in while a result waits. A load
// issues a read request; the next beat must be a load return with the data, any
// other order gives status 3. An unknown opcode, or a pref at or above 0xF0000000,
// halts the unit until reset. Writing cfg_wdata with cfg_we loads the program
// counter; do it only while no beat is in flight.
module risc16_subset_execute_unit_core
    import rsx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_data,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata
);

    // architectural state
    logic [31:0] rf_reg [16];
    arch_t       arch_reg;
    arch_t       arch_next;

    // operand stage
    logic        op_valid_reg;
    in_item_t    op_item_reg;
    logic [31:0] rn_reg;
    logic [31:0] rm_reg;
    logic [31:0] r0_reg;

    // result stage
    logic        res_valid_reg;
    out_item_t   res_reg;
    out_item_t   res_next;

    rf_wr_t      wr_raw;
    rf_wr_t      wr;
    logic        advance;
    logic        take;

    // operand register moves on when the result register is free or being drained
    assign advance  = op_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !op_valid_reg || advance;
    assign take     = in_valid && in_ready;

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    rsx_exec u_exec (
        .item (op_item_reg),
        .rn   (rn_reg),
        .rm   (rm_reg),
        .r0   (r0_reg),
        .cur  (arch_reg),
        .nxt  (arch_next),
        .wr   (wr_raw),
        .res  (res_next)
    );

    // register writes only land when the beat really leaves the operand stage
    always_comb
    begin
        wr      = wr_raw;
        wr.en_a = wr_raw.en_a && advance;
        wr.en_b = wr_raw.en_b && advance;
    end

    // operand read with bypass from the write of the beat ahead
    function automatic logic [31:0] rd_port(input logic [3:0] idx, input rf_wr_t w,
                                            input logic [31:0] raw);
        logic [31:0] v;
        v = raw;
        if (w.en_b && w.addr_b == idx)
            v = w.data_b;
        if (w.en_a && w.addr_a == idx)
            v = w.data_a;
        return v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                rf_reg[i] <= '0;
        end
        else
        begin
            if (wr.en_b)
                rf_reg[wr.addr_b] <= wr.data_b;
            if (wr.en_a)
                rf_reg[wr.addr_a] <= wr.data_a;
        end
    end

    // reset clears every field, which leaves the delay phase at none
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            arch_reg <= '0;
        else if (cfg_we)
            arch_reg.pc <= cfg_wdata;
        else if (advance)
            arch_reg <= arch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                op_valid_reg <= in_valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (out_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_item_reg <= in_data;
            rn_reg      <= rd_port(in_data.opcode[11:8], wr, rf_reg[in_data.opcode[11:8]]);
            rm_reg      <= rd_port(in_data.opcode[7:4], wr, rf_reg[in_data.opcode[7:4]]);
            r0_reg      <= rd_port(4'd0, wr, rf_reg[0]);
        end
        if (advance)
            res_reg <= res_next;
    end

    // a halted unit reports sequencing errors and touches no register
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && arch_reg.halted) |-> (res_next.status == ST_SEQ_ERR && !wr.en_a && !wr.en_b))
        else $error("halted unit changed state");

    // a read request leaves a load pending for the next beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !cfg_we && res_next.mem_op == MEM_READ) |=> arch_reg.ld_pend)
        else $error("read issued without pending load");

    // the result shown after a beat matches the state it left
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !cfg_we) |=> (res_reg.next_pc == arch_reg.pc && res_reg.t_bit == arch_reg.t))
        else $error("result does not match state");

    // a memory request never comes with a non-ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_next.status != ST_OK) |-> (res_next.mem_op == MEM_NONE))
        else $error("memory request on failing beat");

endmodule
`default_nettype wire
